[sv/trd_pkg.sv]
// Shared types and codes for the triangle rasteriser with depth test.
// Command, queue entry and result layouts; used by every module of the block but trd_ram.
// Depends on nothing.
`timescale 1ns / 1ps

package trd_pkg;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_SCAN  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] LAST_VERTEX = 2'd2;

	localparam logic [23:0] FAR_DEPTH_RESET = 24'd256000;

	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_SCAN,
		KIND_CLEAR
	} trd_kind_t;

	typedef struct packed {
		logic [1:0]          operation;
		logic [1:0]          vertex_index;
		logic signed [15:0]  coord_x;
		logic signed [15:0]  coord_y;
		logic [23:0]         inv_depth;
	} trd_cmd_t;

	typedef struct packed {
		trd_kind_t           kind;
		logic [1:0]          vertex_index;
		logic signed [15:0]  coord_x;
		logic signed [15:0]  coord_y;
		logic [23:0]         inv_depth;
	} trd_entry_t;

	typedef struct packed {
		logic [9:0]  pixel_x;
		logic [8:0]  pixel_y;
		logic        drawn;
		logic [23:0] depth;
		logic [15:0] weight_a;
		logic [15:0] weight_b;
		logic [15:0] weight_c;
		logic        last_pixel;
	} trd_result_t;

endpackage

[sv/trd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the depth store; depends on nothing.
`timescale 1ns / 1ps

module trd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 307200
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/trd_front.sv]
// Front end: takes commands and classifies them into queue entries.
// Commands that cause nothing are dropped here. Depends on trd_pkg.
`timescale 1ns / 1ps

module trd_front import trd_pkg::*; #(
	parameter int IMAGE_WIDTH  = 640,
	parameter int IMAGE_HEIGHT = 480
) (
	input  logic       start,
	input  trd_cmd_t   cmd,
	input  logic       full,
	output logic       push,
	output trd_entry_t entry
);

	localparam logic signed [16:0] X_LIMIT = 17'(IMAGE_WIDTH);
	localparam logic signed [16:0] Y_LIMIT = 17'(IMAGE_HEIGHT);

	logic keep;
	logic on_image;

	assign on_image = !cmd.coord_x[15] && !cmd.coord_y[15] &&
		(17'(cmd.coord_x) < X_LIMIT) && (17'(cmd.coord_y) < Y_LIMIT);

	always_comb begin
		entry.vertex_index = cmd.vertex_index;
		entry.coord_x      = cmd.coord_x;
		entry.coord_y      = cmd.coord_y;
		entry.inv_depth    = cmd.inv_depth;
		entry.kind         = KIND_SCAN;
		keep               = 1'b0;
		case (cmd.operation)
			OP_LOAD: begin
				entry.kind = KIND_LOAD;
				keep       = (cmd.vertex_index <= LAST_VERTEX);
			end
			OP_SCAN: begin
				entry.kind = KIND_SCAN;
				keep       = 1'b1;
			end
			OP_CLEAR: begin
				entry.kind = KIND_CLEAR;
				keep       = on_image;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = start && !full && keep;

endmodule

[sv/trd_queue.sv]
// Short register queue between the front end and the back end.
// Depends on trd_pkg for the entry type.
`timescale 1ns / 1ps

module trd_queue import trd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  trd_entry_t push_entry,
	input  logic       pop,
	output trd_entry_t head,
	output logic       valid,
	output logic       full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	trd_entry_t    slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;

	assign valid = (count_q != '0);
	assign full  = (count_q == CW'(DEPTH));
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[sv/trd_back.sv]
// Back end: vertex store, triangle setup, edge functions, shared multiplier,
// shared restoring divider and the depth store. Depends on trd_pkg, trd_ram.
`timescale 1ns / 1ps

module trd_back import trd_pkg::*; #(
	parameter int IMAGE_WIDTH  = 640,
	parameter int IMAGE_HEIGHT = 480,
	parameter int DEPTH_BITS   = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  trd_entry_t  entry,
	input  logic        entry_valid,
	output logic        pop,
	input  logic [23:0] far_depth,
	output trd_result_t result,
	output logic        strobe
);

	localparam int XW = $clog2(IMAGE_WIDTH);
	localparam int YW = $clog2(IMAGE_HEIGHT);
	localparam int NPIX = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int AW = $clog2(NPIX);
	localparam logic [31:0] DEPTH_MAX = 32'((64'd1 << DEPTH_BITS) - 64'd1);
	localparam logic signed [17:0] X_CULL = 18'((IMAGE_WIDTH - 1) * 16);
	localparam logic signed [17:0] Y_CULL = 18'((IMAGE_HEIGHT - 1) * 16);
	localparam logic signed [16:0] X_TOP = 17'(IMAGE_WIDTH - 1);
	localparam logic signed [16:0] Y_TOP = 17'(IMAGE_HEIGHT - 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_AREA, ST_EDGE, ST_COVER, ST_SUM,
		ST_ZCHK, ST_DIVZ, ST_WCHK, ST_DIVW, ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		MPH_AREA, MPH_EDGE, MPH_SUM
	} mph_t;

	function automatic logic signed [15:0] min3(input logic signed [15:0] a,
		input logic signed [15:0] b, input logic signed [15:0] c);
		logic signed [15:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic logic signed [15:0] max3(input logic signed [15:0] a,
		input logic signed [15:0] b, input logic signed [15:0] c);
		logic signed [15:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	state_t              state_q;
	logic signed [15:0]  vx_q [3];
	logic signed [15:0]  vy_q [3];
	logic [23:0]         viz_q [3];
	logic signed [35:0]  area_q;
	logic [XW-1:0]       bx0_q, bx1_q, sx_q;
	logic [YW-1:0]       by0_q, by1_q, sy_q;
	logic                culled_q;
	logic signed [35:0]  e_q [3];
	logic [61:0]         s_q;
	logic                cov_q;
	logic [2:0]          k_q;
	logic signed [43:0]  prod_q;
	logic [2:0]          pk_q;
	mph_t                pph_q;
	logic                pv_q;
	logic [61:0]         rem_q, den_q;
	logic [31:0]         quo_q;
	logic [4:0]          cnt_q;
	logic [DEPTH_BITS-1:0] z_q;
	logic [15:0]         w_q [3];
	logic [1:0]          wi_q;
	trd_result_t         result_q;
	logic                strobe_q;

	// Multiplier operand selection
	logic signed [17:0]  px, py;
	logic signed [24:0]  ma;
	logic signed [18:0]  mb;
	logic signed [35:0]  e_sel;
	logic [23:0]         viz_sel;

	assign px = $signed(18'({sx_q, 4'b1000}));
	assign py = $signed(18'({sy_q, 4'b1000}));

	always_comb begin
		case (k_q[2:1])
			2'd0: begin
				e_sel = e_q[0];
				viz_sel = viz_q[0];
			end
			2'd1: begin
				e_sel = e_q[1];
				viz_sel = viz_q[1];
			end
			default: begin
				e_sel = e_q[2];
				viz_sel = viz_q[2];
			end
		endcase
	end

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_AREA: begin
				if (k_q == 3'd0) begin
					ma = 25'(17'(vx_q[2]) - 17'(vx_q[0]));
					mb = 19'(17'(vy_q[1]) - 17'(vy_q[0]));
				end else begin
					ma = 25'(17'(vy_q[2]) - 17'(vy_q[0]));
					mb = 19'(17'(vx_q[1]) - 17'(vx_q[0]));
				end
			end
			ST_EDGE: begin
				case (k_q)
					3'd0: begin
						ma = 25'(px - 18'(vx_q[1]));
						mb = 19'(17'(vy_q[2]) - 17'(vy_q[1]));
					end
					3'd1: begin
						ma = 25'(py - 18'(vy_q[1]));
						mb = 19'(17'(vx_q[2]) - 17'(vx_q[1]));
					end
					3'd2: begin
						ma = 25'(px - 18'(vx_q[2]));
						mb = 19'(17'(vy_q[0]) - 17'(vy_q[2]));
					end
					3'd3: begin
						ma = 25'(py - 18'(vy_q[2]));
						mb = 19'(17'(vx_q[0]) - 17'(vx_q[2]));
					end
					3'd4: begin
						ma = 25'(px - 18'(vx_q[0]));
						mb = 19'(17'(vy_q[1]) - 17'(vy_q[0]));
					end
					default: begin
						ma = 25'(py - 18'(vy_q[0]));
						mb = 19'(17'(vx_q[1]) - 17'(vx_q[0]));
					end
				endcase
			end
			ST_SUM: begin
				ma = $signed({1'b0, viz_sel});
				mb = k_q[0] ? $signed({1'b0, e_sel[35:18]}) :
					$signed({1'b0, e_sel[17:0]});
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// Bounding box of the freshly loaded triangle
	logic signed [15:0] xmin, xmax, ymin, ymax;
	logic signed [15:0] fx0, fx1, fy0, fy1;
	logic               cull;

	assign xmin = min3(vx_q[0], vx_q[1], vx_q[2]);
	assign xmax = max3(vx_q[0], vx_q[1], vx_q[2]);
	assign ymin = min3(vy_q[0], vy_q[1], vy_q[2]);
	assign ymax = max3(vy_q[0], vy_q[1], vy_q[2]);
	assign fx0 = xmin >>> 4;
	assign fx1 = xmax >>> 4;
	assign fy0 = ymin >>> 4;
	assign fy1 = ymax >>> 4;
	assign cull = (18'(xmin) > X_CULL) || xmax[15] || (18'(ymin) > Y_CULL) || ymax[15];

	// Divider step and depth store addressing
	logic [62:0] r2;
	logic        ge;
	logic [62:0] r2_sub;
	logic        cov;
	logic        last;
	logic        z_sat;
	logic [DEPTH_BITS-1:0] far_sat;
	logic [AW-1:0] pix_addr, clr_addr, waddr;
	logic [DEPTH_BITS-1:0] wdata, stored;
	logic        we;
	logic        drawn;
	logic        take;

	assign r2     = {rem_q, 1'b0};
	assign ge     = (r2 >= {1'b0, den_q});
	assign r2_sub = r2 - {1'b0, den_q};
	assign cov    = !e_q[0][35] && !e_q[1][35] && !e_q[2][35] && (area_q > 36'sd0);
	assign last   = (sx_q == bx1_q) && (sy_q == by1_q);
	assign z_sat  = (s_q == '0) || ((62'(area_q) << (32 - DEPTH_BITS)) >= s_q);
	assign far_sat = (32'(far_depth) > DEPTH_MAX) ? '1 : DEPTH_BITS'(far_depth);
	assign pix_addr = AW'(32'(sy_q) * IMAGE_WIDTH + 32'(sx_q));
	assign clr_addr = AW'(32'($unsigned(entry.coord_y)) * IMAGE_WIDTH +
		32'($unsigned(entry.coord_x)));
	assign drawn = cov_q && (s_q != '0) && (z_q != '0) && (z_q < stored);
	assign take  = (state_q == ST_IDLE) && entry_valid;
	assign pop   = take;

	always_comb begin
		we    = 1'b0;
		waddr = pix_addr;
		wdata = z_q;
		if (take && (entry.kind == KIND_CLEAR)) begin
			we    = 1'b1;
			waddr = clr_addr;
			wdata = far_sat;
		end else if ((state_q == ST_FINISH) && drawn) begin
			we = 1'b1;
		end
	end

	trd_ram #(
		.WIDTH(DEPTH_BITS),
		.DEPTH(NPIX)
	) u_depth_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(pix_addr),
		.rdata(stored)
	);

	// Payload registers without reset
	always_ff @(posedge clk) begin
		if (take && (entry.kind == KIND_LOAD)) begin
			vx_q[entry.vertex_index]  <= entry.coord_x;
			vy_q[entry.vertex_index]  <= entry.coord_y;
			viz_q[entry.vertex_index] <= entry.inv_depth;
		end
		prod_q <= ma * mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			area_q   <= '0;
			bx0_q    <= '0;
			bx1_q    <= '0;
			by0_q    <= '0;
			by1_q    <= '0;
			sx_q     <= '0;
			sy_q     <= '0;
			culled_q <= 1'b1;
			e_q[0]   <= '0;
			e_q[1]   <= '0;
			e_q[2]   <= '0;
			s_q      <= '0;
			cov_q    <= 1'b0;
			k_q      <= '0;
			pk_q     <= '0;
			pph_q    <= MPH_AREA;
			pv_q     <= 1'b0;
			rem_q    <= '0;
			den_q    <= '0;
			quo_q    <= '0;
			cnt_q    <= '0;
			z_q      <= '0;
			w_q[0]   <= '0;
			w_q[1]   <= '0;
			w_q[2]   <= '0;
			wi_q     <= '0;
			result_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			pv_q     <= 1'b0;

			// Accumulate the product issued in the previous cycle.
			if (pv_q) begin
				case (pph_q)
					MPH_AREA: begin
						area_q <= pk_q[0] ? area_q - 36'(prod_q) : area_q + 36'(prod_q);
					end
					MPH_EDGE: begin
						e_q[pk_q[2:1]] <= pk_q[0] ? e_q[pk_q[2:1]] - 36'(prod_q) :
							e_q[pk_q[2:1]] + 36'(prod_q);
					end
					default: begin
						s_q <= pk_q[0] ? s_q + (62'($unsigned(prod_q)) << 18) :
							s_q + 62'($unsigned(prod_q));
					end
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (entry.kind)
							KIND_LOAD: begin
								if (entry.vertex_index == LAST_VERTEX) begin
									area_q  <= '0;
									k_q     <= '0;
									state_q <= ST_AREA;
								end
							end
							KIND_SCAN: begin
								if (culled_q) begin
									result_q <= trd_result_t'{last_pixel: 1'b1, default: '0};
									strobe_q <= 1'b1;
								end else begin
									e_q[0]  <= '0;
									e_q[1]  <= '0;
									e_q[2]  <= '0;
									k_q     <= '0;
									state_q <= ST_EDGE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_AREA: begin
					if (k_q == 3'd2) begin
						k_q     <= '0;
						state_q <= ST_IDLE;
						if (cull) begin
							culled_q <= 1'b1;
						end else begin
							bx0_q <= fx0[15] ? '0 : XW'(fx0);
							bx1_q <= (17'(fx1) > X_TOP) ? XW'(X_TOP) : XW'(fx1);
							by0_q <= fy0[15] ? '0 : YW'(fy0);
							by1_q <= (17'(fy1) > Y_TOP) ? YW'(Y_TOP) : YW'(fy1);
							sx_q  <= fx0[15] ? '0 : XW'(fx0);
							sy_q  <= fy0[15] ? '0 : YW'(fy0);
							culled_q <= 1'b0;
						end
					end else begin
						pv_q  <= 1'b1;
						pk_q  <= k_q;
						pph_q <= MPH_AREA;
						k_q   <= k_q + 3'd1;
					end
				end
				ST_EDGE: begin
					if (k_q == 3'd6) begin
						k_q     <= '0;
						state_q <= ST_COVER;
					end else begin
						pv_q  <= 1'b1;
						pk_q  <= k_q;
						pph_q <= MPH_EDGE;
						k_q   <= k_q + 3'd1;
					end
				end
				ST_COVER: begin
					cov_q  <= cov;
					s_q    <= '0;
					z_q    <= '0;
					w_q[0] <= '0;
					w_q[1] <= '0;
					w_q[2] <= '0;
					state_q <= cov ? ST_SUM : ST_FINISH;
				end
				ST_SUM: begin
					if (k_q == 3'd6) begin
						k_q     <= '0;
						state_q <= ST_ZCHK;
					end else begin
						pv_q  <= 1'b1;
						pk_q  <= k_q;
						pph_q <= MPH_SUM;
						k_q   <= k_q + 3'd1;
					end
				end
				ST_ZCHK: begin
					wi_q <= '0;
					if (z_sat) begin
						z_q     <= DEPTH_BITS'(DEPTH_MAX);
						state_q <= ST_WCHK;
					end else begin
						rem_q   <= 62'(area_q);
						den_q   <= s_q;
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIVZ;
					end
				end
				ST_DIVZ: begin
					rem_q <= ge ? r2_sub[61:0] : r2[61:0];
					quo_q <= {quo_q[30:0], ge};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						z_q     <= DEPTH_BITS'({quo_q[30:0], ge});
						state_q <= ST_WCHK;
					end
				end
				ST_WCHK: begin
					if (e_q[wi_q] >= area_q) begin
						w_q[wi_q] <= 16'hFFFF;
						wi_q      <= wi_q + 2'd1;
						if (wi_q == LAST_VERTEX) begin
							state_q <= ST_FINISH;
						end
					end else begin
						rem_q   <= 62'(e_q[wi_q]);
						den_q   <= 62'(area_q);
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIVW;
					end
				end
				ST_DIVW: begin
					rem_q <= ge ? r2_sub[61:0] : r2[61:0];
					quo_q <= {quo_q[30:0], ge};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						w_q[wi_q] <= {quo_q[14:0], ge};
						wi_q      <= wi_q + 2'd1;
						state_q   <= (wi_q == LAST_VERTEX) ? ST_FINISH : ST_WCHK;
					end
				end
				ST_FINISH: begin
					result_q.pixel_x    <= 10'(sx_q);
					result_q.pixel_y    <= 9'(sy_q);
					result_q.drawn      <= drawn;
					result_q.depth      <= 24'(z_q);
					result_q.weight_a   <= w_q[0];
					result_q.weight_b   <= w_q[1];
					result_q.weight_c   <= w_q[2];
					result_q.last_pixel <= last;
					strobe_q            <= 1'b1;
					if (sx_q < bx1_q) begin
						sx_q <= sx_q + XW'(1);
					end else begin
						sx_q <= bx0_q;
						sy_q <= sy_q + YW'(1);
					end
					if (last) begin
						culled_q <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result = result_q;
	assign strobe = strobe_q;

endmodule

[sv/triangle_raster_depth_test.sv]
// Top level of the triangle rasteriser with depth test.
// Holds the far-depth register and joins front end, queue and back end.
// Depends on trd_pkg, trd_front, trd_queue, trd_back and trd_ram.
`timescale 1ns / 1ps

// A command is taken on a rising edge where start is high and busy is low;
// busy rises only when the command queue is full. Each scan command gives
// exactly one result, shown on result for a single cycle with strobe high;
// the receiver cannot stall it, so it must take every result as it comes.
// Loads, clears and invalid commands give no result.
//
// Work per command in the back end, which handles one command at a time:
// a load of vertex 0 or 1 and a depth clear need no further work; a load of
// vertex 2 also forms the signed area on the shared multiplier. A scan of a
// finished or culled triangle gives one result, marked as the last pixel;
// an uncovered pixel needs the edge products on the single multiplier,
// and a covered pixel also the weighted-sum products and, unless saturated,
// divisions on the shared restoring divider for the depth and for each of
// the three weights. The front end and the four-entry queue keep
// accepting while the back end works, until the queue is full.
//
// The depth store has no clearing pass: every entry must be cleared with a
// clear command before a scan reads it.
module triangle_raster_depth_test import trd_pkg::*; #(
	parameter int IMAGE_WIDTH  = 640,
	parameter int IMAGE_HEIGHT = 480,
	parameter int DEPTH_BITS   = 24,
	parameter int QUEUE_DEPTH  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  trd_cmd_t    cmd,
	output trd_result_t result,
	output logic        strobe,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data
);

	logic [23:0] far_depth_q;
	logic        full;
	logic        push;
	trd_entry_t  push_entry;
	trd_entry_t  head;
	logic        head_valid;
	logic        pop;

	// Far depth register; a transfer on the configuration channel replaces it.
	// The user must make writes only while the block is idle; it is unenforced.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			far_depth_q <= FAR_DEPTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			far_depth_q <= cfg_data;
		end
	end

	// Commands are refused only while the queue has no free slot.
	assign busy = full;

	trd_front #(
		.IMAGE_WIDTH (IMAGE_WIDTH),
		.IMAGE_HEIGHT(IMAGE_HEIGHT)
	) u_front (
		.start(start),
		.cmd  (cmd),
		.full (full),
		.push (push),
		.entry(push_entry)
	);

	trd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.valid     (head_valid),
		.full      (full)
	);

	// The back end owns all triangle state and the depth store.
	trd_back #(
		.IMAGE_WIDTH (IMAGE_WIDTH),
		.IMAGE_HEIGHT(IMAGE_HEIGHT),
		.DEPTH_BITS  (DEPTH_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.entry      (head),
		.entry_valid(head_valid),
		.pop        (pop),
		.far_depth  (far_depth_q),
		.result     (result),
		.strobe     (strobe)
	);

endmodule
